>>> rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants, types and helper functions of the cosine top-k search core.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int MAX_DIM   = 768;
  localparam int MAX_TOP   = 16;
  localparam int LIST_CAP  = (MAX_TOP < 16) ? MAX_TOP : 16;
  localparam int ADDR_W    = $clog2(MAX_DIM);
  localparam int DIMS_W    = 10;
  localparam int TOPK_W    = 5;
  localparam int CNT_W     = $clog2(LIST_CAP + 1);
  localparam int IDX_W     = (LIST_CAP > 1) ? $clog2(LIST_CAP) : 1;
  localparam int VAL_W     = 16;
  localparam int DOC_W     = 16;
  localparam int ACC_W     = 40;
  localparam int DOT_W     = 41;
  localparam int NRM_W     = 2 * ACC_W;
  localparam int RSQ_W     = 2 * DOT_W;
  localparam int SQ_W      = RSQ_W + 32;
  localparam int PRD_W     = NRM_W + 17;
  localparam int MUL_STEPS = DOT_W;
  localparam int ROOT_BITS = 16;
  localparam int STEP_W    = 6;
  localparam int BIT_W     = 4;

  localparam logic [1:0] MODE_QUERY  = 2'd0;
  localparam logic [1:0] MODE_DOC    = 2'd1;
  localparam logic [1:0] MODE_REPORT = 2'd2;

  localparam logic REG_TOP_K = 1'b0;
  localparam logic REG_DIMS  = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ELEM = 6'b000010,
    S_MUL  = 6'b000100,
    S_ROOT = 6'b001000,
    S_INS  = 6'b010000,
    S_RPT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic             accept;
    logic             elem;
    logic             mul;
    logic             root;
    logic             ins;
    logic             rpt;
    logic [BIT_W-1:0] bit_sel;
  } cmd_t;

  typedef struct packed {
    logic doc_end;
    logic out_free;
    logic rpt_last;
  } status_t;

  function automatic logic [CNT_W-1:0] eff_k(input logic [TOPK_W-1:0] k);
    logic [CNT_W-1:0] r;
    if (k == '0) begin
      r = CNT_W'(1);
    end else if (32'(k) > LIST_CAP) begin
      r = CNT_W'(LIST_CAP);
    end else begin
      r = CNT_W'(k);
    end
    return r;
  endfunction

  function automatic logic [DIMS_W:0] eff_dims(input logic [DIMS_W-1:0] d);
    logic [DIMS_W:0] r;
    if (d == '0) begin
      r = (DIMS_W+1)'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = (DIMS_W+1)'(MAX_DIM);
    end else begin
      r = {1'b0, d};
    end
    return r;
  endfunction

endpackage

>>> rtl/cts_ctrl.sv
// ----------------------------------------------------------------------------
// cts_ctrl
// Sequencing state machine: element update, serial multiply, root search,
// list insertion and report streaming.
// ----------------------------------------------------------------------------
module cts_ctrl
  import cts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_mode,
  output logic       in_tready,
  input  status_t    st,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.bit_sel = BIT_W'(ROOT_BITS - 1) - cnt_r[BIT_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          case (in_mode)
            MODE_QUERY, MODE_DOC: state_nxt = S_ELEM;
            MODE_REPORT:          state_nxt = S_RPT;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_ELEM: begin
        cmd.elem  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = st.doc_end ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (cnt_r == STEP_W'(MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_ROOT;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      S_ROOT: begin
        cmd.root = 1'b1;
        if (cnt_r == STEP_W'(ROOT_BITS - 1)) begin
          state_nxt = S_INS;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RPT: begin
        cmd.rpt = 1'b1;
        if (st.out_free && st.rpt_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/cts_dp.sv
// ----------------------------------------------------------------------------
// cts_dp
// Datapath: query memory, accumulators, shift-add multipliers, bitwise root
// search, sorted top list and output register.
// ----------------------------------------------------------------------------
module cts_dp
  import cts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output status_t           st,
  input  logic [1:0]        in_mode,
  input  logic [VAL_W-1:0]  in_value,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [DIMS_W-1:0] cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DOC_W-1:0]  out_doc,
  output logic [15:0]       out_score,
  output logic              out_last,
  output logic              out_empty
);

  logic signed [VAL_W-1:0] q_mem [MAX_DIM];
  logic signed [VAL_W-1:0] rd_r, value_r;
  logic [ADDR_W-1:0]       addr_r;
  logic                    mode_r, start_r, kind_r, qok_r;
  logic [DIMS_W-1:0]       pos_r, dims_r;
  logic [TOPK_W-1:0]       topk_r;
  logic [ACC_W-1:0]        qn_r, dn_r;
  logic signed [DOT_W-1:0] dot_r;
  logic [DOC_W-1:0]        doc_cnt_r;

  logic [NRM_W-1:0] ma_r, n_r;
  logic [ACC_W-1:0] mb_r;
  logic [RSQ_W-1:0] ra_r, r_r;
  logic [DOT_W-1:0] rb_r;
  logic             zero_r, neg_r;
  logic [SQ_W-1:0]  t_r;
  logic [PRD_W-1:0] p_r;
  logic [15:0]      s_r;

  logic [DOC_W-1:0]        ent_doc_r [LIST_CAP];
  logic signed [15:0]      ent_sc_r  [LIST_CAP];
  logic [CNT_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        rpt_r;

  logic                    out_valid_r, out_last_r, out_empty_r;
  logic [DOC_W-1:0]        out_doc_r;
  logic [15:0]             out_score_r;

  logic                    start;
  logic [ADDR_W-1:0]       rd_addr;
  logic signed [31:0]      sq, prod;
  logic [ACC_W-1:0]        qn_nxt, dn_nxt;
  logic signed [DOT_W-1:0] dot_nxt;
  logic [DOT_W-1:0]        mag;
  logic [DIMS_W:0]         pos_inc;
  logic                    vec_end;
  logic [SQ_W-1:0]         trial, rr;
  logic signed [15:0]      score;
  logic [CNT_W-1:0]        k_now, len, ins_pos;
  logic                    full, do_ins;
  logic                    out_free;

  assign start   = (pos_r == '0) || (in_mode[0] != kind_r);
  assign rd_addr = start ? '0 : pos_r[ADDR_W-1:0];

  assign sq      = value_r * value_r;
  assign prod    = rd_r * value_r;
  assign qn_nxt  = (start_r ? '0 : qn_r) + ACC_W'($unsigned(sq));
  assign dn_nxt  = (start_r ? '0 : dn_r) + ACC_W'($unsigned(sq));
  assign dot_nxt = (start_r ? '0 : dot_r) + DOT_W'(prod);
  assign mag     = dot_nxt[DOT_W-1] ? DOT_W'(-dot_nxt) : DOT_W'(dot_nxt);
  assign pos_inc = (DIMS_W+1)'(addr_r) + (DIMS_W+1)'(1);
  assign vec_end = (pos_inc >= eff_dims(dims_r));

  assign rr    = {2'b00, r_r, 30'b0};
  assign trial = t_r + (SQ_W'(p_r) << ((BIT_W+1)'(cmd.bit_sel) + (BIT_W+1)'(1)))
               + (SQ_W'(n_r) << {cmd.bit_sel, 1'b0});

  always_comb begin
    if (zero_r) begin
      score = '0;
    end else if (neg_r) begin
      score = 16'(-{1'b0, s_r});
    end else if (s_r[15]) begin
      score = 16'sd32767;
    end else begin
      score = signed'(s_r);
    end
  end

  assign k_now = eff_k(topk_r);
  assign full  = (cnt_r >= k_now);
  assign len   = full ? cnt_r - CNT_W'(1) : cnt_r;
  assign do_ins = !full || (score > ent_sc_r[IDX_W'(cnt_r - CNT_W'(1))]);

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < LIST_CAP; i++) begin
      if ((CNT_W'(i) < len) && (ent_sc_r[i] >= score)) begin
        ins_pos = ins_pos + CNT_W'(1);
      end
    end
  end

  assign out_free    = !out_valid_r || out_ready;
  assign st.out_free = out_free;
  assign st.rpt_last = (cnt_r == '0) || ((CNT_W'(rpt_r) + CNT_W'(1)) == cnt_r);
  assign st.doc_end  = cmd.elem && mode_r && vec_end;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_r <= q_mem[rd_addr];
    end
    if (cmd.elem && !mode_r) begin
      q_mem[addr_r] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value_r <= in_value;
      mode_r  <= in_mode[0];
      start_r <= start;
      addr_r  <= rd_addr;
    end
    if (st.doc_end) begin
      ma_r   <= NRM_W'(qn_r);
      mb_r   <= dn_nxt;
      ra_r   <= RSQ_W'(mag);
      rb_r   <= mag;
      n_r    <= '0;
      r_r    <= '0;
      t_r    <= '0;
      p_r    <= '0;
      s_r    <= '0;
      zero_r <= !qok_r || (qn_r == '0) || (dn_nxt == '0);
      neg_r  <= dot_nxt[DOT_W-1];
    end
    if (cmd.mul) begin
      if (mb_r[0]) begin
        n_r <= n_r + ma_r;
      end
      if (rb_r[0]) begin
        r_r <= r_r + ra_r;
      end
      ma_r <= ma_r << 1;
      mb_r <= mb_r >> 1;
      ra_r <= ra_r << 1;
      rb_r <= rb_r >> 1;
    end
    if (cmd.root && (trial <= rr)) begin
      t_r <= trial;
      p_r <= p_r + (PRD_W'(n_r) << cmd.bit_sel);
      s_r[cmd.bit_sel] <= 1'b1;
    end
    if (cmd.ins && do_ins) begin
      for (int i = 0; i < LIST_CAP; i++) begin
        if (CNT_W'(i) == ins_pos) begin
          ent_doc_r[i] <= doc_cnt_r;
          ent_sc_r[i]  <= score;
        end else if ((CNT_W'(i) > ins_pos) && (i > 0)) begin
          ent_doc_r[i] <= ent_doc_r[(i > 0) ? i - 1 : 0];
          ent_sc_r[i]  <= ent_sc_r[(i > 0) ? i - 1 : 0];
        end
      end
    end
    if (cmd.rpt && out_free) begin
      out_doc_r   <= (cnt_r == '0) ? '0 : ent_doc_r[rpt_r];
      out_score_r <= (cnt_r == '0) ? '0 : ent_sc_r[rpt_r];
      out_last_r  <= st.rpt_last;
      out_empty_r <= (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      kind_r      <= 1'b0;
      qok_r       <= 1'b0;
      qn_r        <= '0;
      dn_r        <= '0;
      dot_r       <= '0;
      doc_cnt_r   <= '0;
      cnt_r       <= '0;
      rpt_r       <= '0;
      topk_r      <= TOPK_W'(5);
      dims_r      <= DIMS_W'(MAX_DIM);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rpt_r <= '0;
        if (!in_mode[1]) begin
          kind_r <= in_mode[0];
        end
      end
      if (cmd.elem) begin
        pos_r <= vec_end ? '0 : pos_inc[DIMS_W-1:0];
        if (!mode_r) begin
          qn_r <= qn_nxt;
          if (vec_end) begin
            qok_r <= 1'b1;
          end else if (start_r) begin
            qok_r <= 1'b0;
          end
          if (start_r) begin
            cnt_r     <= '0;
            doc_cnt_r <= '0;
          end
        end else begin
          dn_r  <= dn_nxt;
          dot_r <= dot_nxt;
        end
      end
      if (cmd.ins) begin
        if (!full) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (doc_cnt_r != '1) begin
          doc_cnt_r <= doc_cnt_r + DOC_W'(1);
        end
      end
      if (cmd.rpt && out_free) begin
        rpt_r <= rpt_r + IDX_W'(1);
      end
      if (cmd.rpt && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_TOP_K: begin
            topk_r <= cfg_data[TOPK_W-1:0];
            if (cnt_r > eff_k(cfg_data[TOPK_W-1:0])) begin
              cnt_r <= eff_k(cfg_data[TOPK_W-1:0]);
            end
          end
          REG_DIMS: begin
            dims_r <= cfg_data;
            pos_r  <= '0;
            qok_r  <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_doc   = out_doc_r;
  assign out_score = out_score_r;
  assign out_last  = out_last_r;
  assign out_empty = out_empty_r;

endmodule

>>> rtl/cosine_top_k_search_core.sv
// ----------------------------------------------------------------------------
// cosine_top_k_search_core
// Cosine-similarity top-k search over signed Q1.15 vectors.
// ----------------------------------------------------------------------------
// One item is handled at a time. A query or document element is accepted, then
// goes through the memory read and multiply-accumulate. The last element of a
// document adds a serial multiplication of the norms and of the squared dot
// product, a bitwise square-root search and a list insertion. A report is
// accepted and then returns one beat per cycle while the output side is ready.
// Configuration writes are taken in any cycle.
module cosine_top_k_search_core
  import cts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // value
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // score (31:16), doc_num (15:0)
  output logic        out_tlast,
  output logic        out_tuser,  // empty_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);

  cmd_t       cmd;
  status_t    st;
  logic [DOC_W-1:0] out_doc;
  logic [15:0]      out_score;

  assign cfg_ready = 1'b1;

  cts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  cts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_mode   (in_tuser),
    .in_value  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_doc   (out_doc),
    .out_score (out_score),
    .out_last  (out_tlast),
    .out_empty (out_tuser)
  );

  assign out_tdata = {out_score, out_doc};

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cosine top-k search core: a behavioral scorer
// and ranked list predict every report beat; stimulus is directed and random
// with bursty input, stalling output and mid-run register changes.
// ----------------------------------------------------------------------------
module tb_top;
  import cts_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [15:0]        doc;
    logic signed [15:0] score;
    logic               last;
    logic               empty;
  } hit_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [9:0]  cfg_data;

  cosine_top_k_search_core dut (.*);

  // Predictor state.
  logic signed [15:0] q_mem [MAX_DIM];
  longint unsigned    q_norm, d_norm;
  longint             dot;
  int                 pos, doc_cnt, list_len, kind, q_written;
  bit                 q_valid;
  int                 rank_doc [16];
  int                 rank_score [16];
  int                 k_reg, dims_reg;

  hit_t pending_hits[$];
  int   fails;
  int   burst_left;
  int   hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int k_eff();
    if (k_reg == 0) return 1;
    return (k_reg > LIST_CAP) ? LIST_CAP : k_reg;
  endfunction

  function automatic int dims_eff();
    if (dims_reg == 0) return 1;
    return (dims_reg > MAX_DIM) ? MAX_DIM : dims_reg;
  endfunction

  function automatic int cosine_q15();
    logic [127:0] norms, rhs, mag;
    int lo, hi, mid;
    if (!q_valid || q_norm == 0 || d_norm == 0) return 0;
    mag = (dot < 0) ? 128'(-dot) : 128'(dot);
    norms = 128'(q_norm) * 128'(d_norm);
    rhs = (mag * mag) << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (norms * 128'(mid) * 128'(mid) <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (dot < 0) return -lo;
    return (lo > 32767) ? 32767 : lo;
  endfunction

  task automatic rank_insert(input int doc, input int score);
    int i, t;
    if (list_len < k_eff()) begin
      i = list_len;
      list_len++;
    end else if (score > rank_score[list_len-1]) begin
      i = list_len - 1;
    end else begin
      return;
    end
    rank_doc[i] = doc;
    rank_score[i] = score;
    while (i > 0 && rank_score[i] > rank_score[i-1]) begin
      t = rank_doc[i]; rank_doc[i] = rank_doc[i-1]; rank_doc[i-1] = t;
      t = rank_score[i]; rank_score[i] = rank_score[i-1]; rank_score[i-1] = t;
      i--;
    end
  endtask

  task automatic predict_item(input logic [1:0] mode, input logic signed [15:0] v);
    hit_t h;
    longint sv;
    sv = v;
    if (mode == MODE_REPORT) begin
      if (list_len == 0) begin
        h = '{doc: 16'd0, score: 16'sd0, last: 1'b1, empty: 1'b1};
        pending_hits.push_back(h);
      end
      for (int i = 0; i < list_len; i++) begin
        h = '{doc: 16'(rank_doc[i]), score: 16'(rank_score[i]),
              last: (i + 1 == list_len), empty: 1'b0};
        pending_hits.push_back(h);
      end
      return;
    end
    if (mode == MODE_UNUSED) return;
    if (pos != 0 && mode != kind) pos = 0;
    if (pos == 0) begin
      kind = mode;
      if (mode == MODE_QUERY) begin
        q_valid = 0;
        q_norm = 0;
        list_len = 0;
        doc_cnt = 0;
      end else begin
        dot = 0;
        d_norm = 0;
      end
    end
    if (pos >= MAX_DIM) pos = 0;
    if (mode == MODE_QUERY) begin
      q_mem[pos] = v;
      if (pos + 1 > q_written) q_written = pos + 1;
      q_norm += longint'(sv * sv);
    end else begin
      dot += longint'(q_mem[pos]) * sv;
      d_norm += longint'(sv * sv);
    end
    pos++;
    if (pos >= dims_eff()) begin
      pos = 0;
      if (mode == MODE_QUERY) begin
        q_valid = 1;
      end else begin
        rank_insert(doc_cnt, cosine_q15());
        if (doc_cnt < 65535) doc_cnt++;
      end
    end
  endtask

  task automatic send_beat(input logic [1:0] mode, input logic signed [15:0] v);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = mode;
    in_tdata = v;
    do @(posedge clk); while (!in_tready);
    predict_item(mode, v);
    if (burst_left == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(5, 0)) @(negedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (pending_hits.size() == 0);
    repeat (2 * dims_eff() + 80) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val[9:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TOP_K) begin
      k_reg = val & 31;
      if (list_len > k_eff()) list_len = k_eff();
    end else begin
      dims_reg = val & 1023;
      pos = 0;
      q_valid = 0;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7, 0))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'(int'($urandom_range(64, 0)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(input logic [1:0] mode, input int n, input int style);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: send_beat(mode, pick_value());
        1: send_beat(mode, q_mem[i]);
        2: send_beat(mode, -q_mem[i]);
        default: send_beat(mode, 16'sd0);
      endcase
    end
  endtask

  task automatic test_empty_and_unused();
    send_beat(MODE_REPORT, 16'sh7fff);
    send_beat(MODE_UNUSED, 16'sh8000);
    send_beat(MODE_UNUSED, 16'shffff);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_TOP_K, 0);
    write_reg(REG_DIMS, 0);
    send_beat(MODE_QUERY, 16'sh8000);
    send_beat(MODE_DOC, 16'sh7fff);
    send_beat(MODE_DOC, 16'sh8000);
    send_beat(MODE_DOC, 16'sd0);
    send_beat(MODE_REPORT, 16'sd0);
    write_reg(REG_TOP_K, 31);
    send_beat(MODE_DOC, 16'sd1);
    send_beat(MODE_DOC, 16'sh8000);
    send_beat(MODE_REPORT, 16'sd0);
  endtask

  task automatic test_full_length();
    write_reg(REG_DIMS, 1023);
    send_vector(MODE_QUERY, 12, 0);
    send_beat(MODE_REPORT, 16'sd0);
    send_vector(MODE_DOC, 12, 1);
    send_vector(MODE_DOC, 12, 2);
    send_vector(MODE_DOC, 3, 0);
    send_beat(MODE_REPORT, 16'sd0);
    send_beat(MODE_QUERY, 16'sd5);
    send_beat(MODE_REPORT, 16'sd0);
  endtask

  task automatic test_no_query();
    write_reg(REG_DIMS, 2);
    write_reg(REG_TOP_K, 3);
    send_vector(MODE_DOC, 2, 0);
    send_beat(MODE_REPORT, 16'sd0);
    send_vector(MODE_QUERY, 2, 3);
    send_vector(MODE_DOC, 2, 0);
    send_beat(MODE_REPORT, 16'sd0);
  endtask

  task automatic test_random_search();
    int items, d, n;
    items = 0;
    while (items < 40) begin
      if ($urandom_range(1, 0)) write_reg(REG_TOP_K, $urandom_range(6, 0) == 0 ?
                                          $urandom_range(31, 17) : $urandom_range(16, 1));
      d = ($urandom_range(5, 0) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
      write_reg(REG_DIMS, d);
      send_vector(MODE_QUERY, d, ($urandom_range(9, 0) == 0) ? 3 : 0);
      items += d;
      n = $urandom_range(8, 2);
      for (int j = 0; j < n; j++) begin
        case ($urandom_range(9, 0))
          0: begin
            send_vector(MODE_DOC, $urandom_range(d, 1), 0);
            send_beat(MODE_REPORT, 16'sd0);
            send_beat(MODE_UNUSED, 16'($urandom));
          end
          1: send_vector(MODE_DOC, d, 1 + $urandom_range(2, 0));
          default: send_vector(MODE_DOC, d, 0);
        endcase
        items += d;
      end
      send_beat(MODE_REPORT, 16'($urandom));
      if ($urandom_range(4, 0) == 0) begin
        send_beat(MODE_DOC, pick_value());
        send_beat(MODE_QUERY, pick_value());
        send_beat(MODE_REPORT, 16'sd0);
      end
      items++;
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_TOP_K, 16);
    write_reg(REG_DIMS, 3);
    send_vector(MODE_QUERY, 3, 0);
    repeat (16) send_vector(MODE_DOC, 3, 0);
    wait_drained();
    hold_cycles = 400;
    repeat (4) send_beat(MODE_REPORT, 16'sd0);
    wait_drained();
  endtask

  // Receiver: random stall pattern that changes density, plus forced hold-offs.
  initial begin
    int density;
    int phase;
    out_tready = 1'b0;
    density = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 1'b0;
        hold_cycles--;
      end else begin
        if (phase == 0) begin
          density = $urandom_range(4, 0);
          phase = $urandom_range(80, 10);
        end
        phase--;
        out_tready = (density == 0) ? 1'b1 : ($urandom_range(4, 0) >= density);
      end
    end
  end

  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected beat: tdata %h", out_tdata);
        fails++;
      end else begin
        want = pending_hits.pop_front();
        if (out_tdata[15:0] !== want.doc) begin
          $error("doc_num: expected %0d, got %0d", want.doc, out_tdata[15:0]);
          fails++;
        end
        if (out_tdata[31:16] !== want.score) begin
          $error("score: expected %0d, got %0d", want.score, $signed(out_tdata[31:16]));
          fails++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          fails++;
        end
        if (out_tuser !== want.empty) begin
          $error("empty_res: expected %0b, got %0b", want.empty, out_tuser);
          fails++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    fails = 0;
    burst_left = 0;
    hold_cycles = 0;
    q_norm = 0; d_norm = 0; dot = 0;
    pos = 0; doc_cnt = 0; list_len = 0; kind = 0; q_written = 0;
    q_valid = 0;
    k_reg = 5;
    dims_reg = 768;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_empty_and_unused();
    test_register_extremes();
    test_full_length();
    test_no_query();
    test_random_search();
    test_backpressure();
    wait_drained();
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
